### design/rbs_pkg.sv
// rbs_pkg: shared types and constants for the ray/box slab intersect block
// no dependencies
package rbs_pkg;
	localparam int CW = 32;
	localparam int FB = 16;
	localparam int NW = CW + 1 + FB;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X = 3'd0, REG_MIN_Y = 3'd1, REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3, REG_MAX_Y = 3'd4, REG_MAX_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] origin_x;
		logic signed [CW-1:0] origin_y;
		logic signed [CW-1:0] origin_z;
		logic signed [CW-1:0] direction_x;
		logic signed [CW-1:0] direction_y;
		logic signed [CW-1:0] direction_z;
		logic signed [CW-1:0] t_start;
		logic signed [CW-1:0] t_end;
	} ray_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] t_entry;
		logic signed [CW-1:0] t_exit;
	} res_t;

	// per-axis outcome handed from a lane to the merge stage
	typedef struct packed {
		logic                 zero_dir;
		logic                 in_slab;
		logic signed [CW-1:0] t_near;
		logic signed [CW-1:0] t_far;
	} lane_res_t;
endpackage

### design/ray_box_slab_intersect_top.sv
// ray_box_slab_intersect_top: ray vs box slab test, three axis lanes and a merge
// depends on rbs_pkg, rbs_lane, rbs_merge
//
// Usage:
//  - in channel: in_valid/in_stall with a ray_t word (origin, direction, t range)
//  - out channel: out_valid/out_stall with a res_t word (hit, t_entry, t_exit)
//  - cfg channel: cfg_valid/cfg_ready, cfg_index 0..5 selects the box corner
//    register, higher indexes are ignored; cfg_ready is always high
//  - throughput: one ray per cycle while the output is not stalled; an
//    accepted ray passes the operand registers, the 49-stage restoring
//    dividers (one quotient bit each), the merge and output registers
//  - the whole pipeline advances together; while out_stall holds a valid word
//    the pipeline freezes and in_stall is raised
//  - reset clears the box registers to zero and all valid flags
module ray_box_slab_intersect_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  rbs_pkg::ray_t                in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output rbs_pkg::res_t                out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbs_pkg::CW-1:0]       cfg_data
);
	import rbs_pkg::*;

	localparam int PIPE = NW + 3;

	logic signed [CW-1:0] bmin_q [3];
	logic signed [CW-1:0] bmax_q [3];
	logic [PIPE-1:0] vld_q;
	logic [CW-1:0] t0_q [PIPE-1];
	logic [CW-1:0] t1_q [PIPE-1];
	logic en;
	lane_res_t lr [3];
	res_t mres;

	assign cfg_ready = 1'b1;

	// box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				bmin_q[i] <= '0;
				bmax_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_X: bmin_q[0] <= cfg_data;
				REG_MIN_Y: bmin_q[1] <= cfg_data;
				REG_MIN_Z: bmin_q[2] <= cfg_data;
				REG_MAX_X: bmax_q[0] <= cfg_data;
				REG_MAX_Y: bmax_q[1] <= cfg_data;
				REG_MAX_Z: bmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves unless the output word is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE-2:0], in_valid};
		end
	end

	// interval bounds travel with the ray
	always_ff @(posedge clk) begin
		if (en) begin
			t0_q[0] <= in_data.t_start;
			t1_q[0] <= in_data.t_end;
			for (int i = 1; i < PIPE-1; i++) begin
				t0_q[i] <= t0_q[i-1];
				t1_q[i] <= t1_q[i-1];
			end
		end
	end

	rbs_lane u_lane_x (.clk, .en, .bmin(bmin_q[0]), .bmax(bmax_q[0]),
		.org(in_data.origin_x), .dir(in_data.direction_x), .res(lr[0]));
	rbs_lane u_lane_y (.clk, .en, .bmin(bmin_q[1]), .bmax(bmax_q[1]),
		.org(in_data.origin_y), .dir(in_data.direction_y), .res(lr[1]));
	rbs_lane u_lane_z (.clk, .en, .bmin(bmin_q[2]), .bmax(bmax_q[2]),
		.org(in_data.origin_z), .dir(in_data.direction_z), .res(lr[2]));

	rbs_merge u_merge (.clk, .en, .lx(lr[0]), .ly(lr[1]), .lz(lr[2]),
		.t0(t0_q[PIPE-3]), .t1(t1_q[PIPE-3]), .res(mres));

	// output register
	always_ff @(posedge clk) begin
		if (en) out_data <= mres;
	end
	assign out_valid = vld_q[PIPE-1];
endmodule

### design/rbs_div.sv
// rbs_div: pipelined restoring divider, one quotient bit per stage, saturating
// depends on rbs_pkg
module rbs_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rbs_pkg::NW-1:0]       num_mag,
	input  logic [rbs_pkg::CW-1:0]       den_mag,
	input  logic                         neg,
	output logic signed [rbs_pkg::CW-1:0] quo
);
	import rbs_pkg::*;

	// remainder, quotient so far and remaining numerator per stage
	logic [CW:0]   rem_q [1:NW-1];
	logic [NW-1:0] quo_q [1:NW];
	logic [NW-1:0] num_q [1:NW-1];
	logic [CW-1:0] den_q [1:NW-1];
	logic          neg_q [1:NW];
	logic [CW-1:0] limit;
	logic          ovf;

	// one restoring step per stage
	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [CW:0]   rem_in;
		logic [NW-1:0] quo_in;
		logic [NW-1:0] num_in;
		logic [CW-1:0] den_in;
		logic          neg_in;
		logic [CW+1:0] trial;
		logic          fits;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num_mag;
			assign den_in = den_mag;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_q[i];
			assign quo_in = quo_q[i];
			assign num_in = num_q[i];
			assign den_in = den_q[i];
			assign neg_in = neg_q[i];
		end

		assign trial = {rem_in, num_in[NW-1]};
		assign fits  = trial >= {2'b00, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[i+1] <= {quo_in[NW-2:0], fits};
				neg_q[i+1] <= neg_in;
			end
		end

		// partial remainder and operands for the next stage
		if (i < NW-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i+1] <= fits ? (CW+1)'(trial - {2'b00, den_in}) : trial[CW:0];
					num_q[i+1] <= {num_in[NW-2:0], 1'b0};
					den_q[i+1] <= den_in;
				end
			end
		end
	end

	// saturate to the signed range, then apply sign
	always_comb begin
		limit = neg_q[NW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		ovf   = quo_q[NW] > NW'(limit);
		quo   = neg_q[NW] ? -(ovf ? limit : quo_q[NW][CW-1:0])
		                  :  (ovf ? limit : quo_q[NW][CW-1:0]);
	end
endmodule

### design/rbs_lane.sv
// rbs_lane: one axis of the slab test, two dividers and the near/far order
// depends on rbs_pkg, rbs_div
module rbs_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [rbs_pkg::CW-1:0] bmin,
	input  logic signed [rbs_pkg::CW-1:0] bmax,
	input  logic signed [rbs_pkg::CW-1:0] org,
	input  logic signed [rbs_pkg::CW-1:0] dir,
	output rbs_pkg::lane_res_t            res
);
	import rbs_pkg::*;

	localparam int LAT = NW + 1;

	logic signed [CW:0] dmin, dmax;
	logic [CW:0]        mmin, mmax;
	logic [CW-1:0]      dmag;
	logic [NW-1:0]      nmin_s1, nmax_s1;
	logic [CW-1:0]      dmag_s1;
	logic               negn_s1, negx_s1;
	logic signed [CW-1:0] qmin, qmax;
	logic               zero_q [LAT];
	logic               in_slab_q [LAT];

	// exact differences and magnitudes
	always_comb begin
		dmin = (CW+1)'(bmin) - (CW+1)'(org);
		dmax = (CW+1)'(bmax) - (CW+1)'(org);
		mmin = dmin[CW] ? -dmin : dmin;
		mmax = dmax[CW] ? -dmax : dmax;
		dmag = dir[CW-1] ? -dir : dir;
	end

	// operand registers; zero-direction info rides alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			nmin_s1 <= {mmin, {FB{1'b0}}};
			nmax_s1 <= {mmax, {FB{1'b0}}};
			dmag_s1 <= dmag;
			negn_s1 <= dmin[CW] ^ dir[CW-1];
			negx_s1 <= dmax[CW] ^ dir[CW-1];
			zero_q[0]    <= dir == '0;
			in_slab_q[0] <= (org >= bmin) && (org <= bmax);
			for (int i = 1; i < LAT; i++) begin
				zero_q[i]    <= zero_q[i-1];
				in_slab_q[i] <= in_slab_q[i-1];
			end
		end
	end

	rbs_div u_div_min (.clk, .en, .num_mag(nmin_s1), .den_mag(dmag_s1),
		.neg(negn_s1), .quo(qmin));
	rbs_div u_div_max (.clk, .en, .num_mag(nmax_s1), .den_mag(dmag_s1),
		.neg(negx_s1), .quo(qmax));

	// order the two plane distances
	always_comb begin
		res.zero_dir = zero_q[LAT-1];
		res.in_slab  = in_slab_q[LAT-1];
		res.t_near   = (qmin > qmax) ? qmax : qmin;
		res.t_far    = (qmin > qmax) ? qmin : qmax;
	end
endmodule

### design/rbs_merge.sv
// rbs_merge: combines the three lane outcomes into the clipped interval
// depends on rbs_pkg
module rbs_merge (
	input  logic                          clk,
	input  logic                          en,
	input  rbs_pkg::lane_res_t            lx,
	input  rbs_pkg::lane_res_t            ly,
	input  rbs_pkg::lane_res_t            lz,
	input  logic signed [rbs_pkg::CW-1:0] t0,
	input  logic signed [rbs_pkg::CW-1:0] t1,
	output rbs_pkg::res_t                 res
);
	import rbs_pkg::*;

	logic signed [CW-1:0] a0, a1, b0, b1, c0, c1, c0_s1, c1_s1;
	logic ha, hb, hit_s1;
	lane_res_t lz_s1;

	function automatic logic [2*CW:0] clip(lane_res_t l, logic signed [CW-1:0] lo,
		logic signed [CW-1:0] hi);
		logic signed [CW-1:0] nlo, nhi;
		logic h;
		begin
			nlo = lo;
			nhi = hi;
			h = 1'b1;
			if (l.zero_dir) begin
				h = l.in_slab;
			end else begin
				if (l.t_near > nlo) nlo = l.t_near;
				if (l.t_far < nhi) nhi = l.t_far;
			end
			if (nlo > nhi) h = 1'b0;
			return {h, nlo, nhi};
		end
	endfunction

	// x and y axes, registered, then z
	always_comb begin
		{ha, a0, a1} = clip(lx, t0, t1);
		{hb, b0, b1} = clip(ly, a0, a1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1 <= ha && hb;
			c0_s1  <= b0;
			c1_s1  <= b1;
			lz_s1  <= lz;
		end
	end

	logic hc;
	always_comb begin
		{hc, c0, c1} = clip(lz_s1, c0_s1, c1_s1);
		res.hit     = hit_s1 && hc;
		res.t_entry = res.hit ? c0 : '0;
		res.t_exit  = res.hit ? c1 : '0;
	end
endmodule

### design/rbs_checker.sv
// rbs_checker: port-level assertions for the slab intersect top level
// depends on rbs_pkg; bound to ray_box_slab_intersect_top
module rbs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input rbs_pkg::res_t out_data
);
	import rbs_pkg::*;

	// a miss carries a zero interval
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.t_entry == '0 && out_data.t_exit == '0)
		else $error("miss with nonzero interval");

	// a hit carries an ordered interval
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.t_entry <= out_data.t_exit)
		else $error("hit with entry after exit");

	// input stalls only while the output word is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

	// held output word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output changed");
endmodule

bind ray_box_slab_intersect_top rbs_checker u_rbs_checker (.*);

### tb/ray_box_slab_intersect_checker.sv
// ray_box_slab_intersect_checker: watches the ray and result channels, predicts each result
// from its own copy of the box registers and compares in order
// depends on rbs_pkg
module ray_box_slab_intersect_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  rbs_pkg::ray_t                 in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  rbs_pkg::res_t                 out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbs_pkg::CW-1:0]        cfg_data,
	output int                            fail_count,
	output int                            pending_count,
	output int                            hit_count,
	output int                            result_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import rbs_pkg::*;

	logic signed [CW-1:0] lo_corner [3];
	logic signed [CW-1:0] hi_corner [3];
	res_t expected_hits [$];

	// saturated fixed point distance (plane - origin) / dir, truncated toward zero
	function automatic logic signed [CW-1:0] plane_dist(logic signed [CW-1:0] plane,
			logic signed [CW-1:0] orig, logic signed [CW-1:0] dir);
		logic signed [127:0] num;
		logic signed [127:0] quo;
		num = ($signed({{96{plane[CW-1]}}, plane}) - $signed({{96{orig[CW-1]}}, orig})) <<< FB;
		quo = num / $signed({{96{dir[CW-1]}}, dir});
		if (quo > 128'sd2147483647)
			return 32'sh7fffffff;
		if (quo < -128'sd2147483648)
			return 32'sh80000000;
		return quo[CW-1:0];
	endfunction

	// slab test over the three axes in order
	function automatic res_t clip_ray(ray_t r);
		logic signed [CW-1:0] org [3];
		logic signed [CW-1:0] dir [3];
		logic signed [CW-1:0] t0, t1, tn, tf, tmp;
		logic hit;
		res_t res;
		org = '{r.origin_x, r.origin_y, r.origin_z};
		dir = '{r.direction_x, r.direction_y, r.direction_z};
		t0 = r.t_start;
		t1 = r.t_end;
		hit = 1'b1;
		for (int a = 0; a < 3 && hit; a++) begin
			if (dir[a] == 0) begin
				if (org[a] < lo_corner[a] || org[a] > hi_corner[a])
					hit = 1'b0;
			end else begin
				tn = plane_dist(lo_corner[a], org[a], dir[a]);
				tf = plane_dist(hi_corner[a], org[a], dir[a]);
				if (tn > tf) begin
					tmp = tn;
					tn = tf;
					tf = tmp;
				end
				if (tn > t0)
					t0 = tn;
				if (tf < t1)
					t1 = tf;
			end
			if (t0 > t1)
				hit = 1'b0;
		end
		res.hit = hit;
		res.t_entry = hit ? t0 : '0;
		res.t_exit = hit ? t1 : '0;
		return res;
	endfunction

	assign pending_count = expected_hits.size();

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				lo_corner[a] = '0;
				hi_corner[a] = '0;
			end
			expected_hits.delete();
			fail_count <= 0;
			hit_count <= 0;
			result_count <= 0;
		end else begin
			// compare the result word against the oldest expectation first
			if (out_valid && !out_stall) begin
				result_count <= result_count + 1;
				if (expected_hits.size() == 0) begin
					$display("%0t: unexpected result word %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_hits.pop_front();
					if (want.hit) hit_count <= hit_count + 1;
					if (out_data.hit !== want.hit || out_data.t_entry !== want.t_entry ||
							out_data.t_exit !== want.t_exit) begin
						$display("%0t: expected hit=%0d entry=%0d exit=%0d, got hit=%0d entry=%0d exit=%0d",
							$time, want.hit, want.t_entry, want.t_exit,
							out_data.hit, out_data.t_entry, out_data.t_exit);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_hits.push_back(clip_ray(in_data));
			// box register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < 3)
					lo_corner[cfg_index] = cfg_data;
				else if (cfg_index < 6)
					hi_corner[cfg_index - 3] = cfg_data;
			end
		end
	end
endmodule

### tb/ray_box_slab_intersect_top_tb.sv
// ray_box_slab_intersect_top_tb: stimulus and verdict for the ray/box slab intersect block
// depends on rbs_pkg, ray_box_slab_intersect_top, ray_box_slab_intersect_checker
module ray_box_slab_intersect_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rbs_pkg::*;

	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	ray_t in_data;
	logic out_valid;
	logic out_stall;
	res_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CW-1:0] cfg_data;
	int fail_count, pending_count, hit_count, result_count;
	int rays_sent;
	bit quiet_tail;
	bit long_hold;

	ray_box_slab_intersect_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ray_box_slab_intersect_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count),
		.hit_count(hit_count), .result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3ms;
		$display("ray_box_slab_intersect_top: mismatch");
		$finish;
	end

	// biased coordinate: extremes, small values near the box, or anything
	function automatic logic [CW-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return '0;
			3, 4, 5: return $urandom_range(0, 32'h000a0000) - 32'h00050000;
			6: return $urandom_range(0, 32'h00000400) - 32'h00000200;
			default: return $urandom;
		endcase
	endfunction

	function automatic ray_t random_ray();
		ray_t r;
		r.origin_x = pick_coord();
		r.origin_y = pick_coord();
		r.origin_z = pick_coord();
		r.direction_x = ($urandom_range(0, 5) == 0) ? '0 : pick_coord();
		r.direction_y = ($urandom_range(0, 5) == 0) ? '0 : pick_coord();
		r.direction_z = ($urandom_range(0, 5) == 0) ? '0 : pick_coord();
		if ($urandom_range(0, 4) == 0) begin
			r.t_start = pick_coord();
			r.t_end = pick_coord();
		end else begin
			r.t_start = 32'h80000000 + $urandom_range(0, 3);
			r.t_end = 32'h7fffffff - $urandom_range(0, 3);
		end
		return r;
	endfunction

	// send one ray word, with an optional burst of idle cycles first
	task automatic send_ray(ray_t r);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		rays_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_box(logic [CW-1:0] mn [3], logic [CW-1:0] mx [3]);
		cfg_reg_t idx [6];
		idx = '{REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= (i < 3) ? mn[i] : mx[i - 3];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		// index beyond the box registers is ignored
		cfg_index <= 3'd7;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [CW-1:0] mn [3];
		logic [CW-1:0] mx [3];
		ray_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rays_sent = 0;
		quiet_tail = 1'b0;
		long_hold = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rays against a box from -1.0 to 1.0 on each axis, centered at the origin
		mn = '{32'hffff0000, 32'hffff0000, 32'hffff0000};
		mx = '{32'h00010000, 32'h00010000, 32'h00010000};
		write_box(mn, mx);
		@(posedge clk);
		send_ray('{32'hfffe0000, 0, 0, 32'h00010000, 0, 0, 0, 32'h00100000});
		send_ray('{32'h00020000, 0, 0, 32'hffff0000, 0, 0, 0, 32'h00100000});
		send_ray('{0, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff});
		send_ray('{0, 32'h00020000, 0, 0, 0, 0, 0, 32'h00010000});
		send_ray('{0, 0, 0, 32'h00010000, 32'h00010000, 32'h00010000,
			32'h00010000, 0});
		send_ray('{32'h80000000, 0, 0, 1, 0, 0, 32'h80000000, 32'h7fffffff});
		send_ray('{32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 32'h80000000,
			32'h7fffffff});
		send_ray('{32'hfffe0000, 32'hfffe0000, 32'hfffe0000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
		send_ray('{32'h00010000, 32'hffff0000, 0, 0, 0, 0, 0, 0});
		send_ray('{32'h00005000, 0, 0, 32'h00000001, 32'h00000003, 0, 0,
			32'h7fffffff});
		send_ray('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
		drain();

		// reversed corners: a zero direction misses, others swap planes
		write_box(mx, mn);
		send_ray('{0, 0, 0, 0, 0, 0, 0, 32'h00010000});
		send_ray('{32'hfffe0000, 0, 0, 32'h00010000, 32'h00000100, 32'h00000100,
			32'h80000000, 32'h7fffffff});
		drain();

		// random phases over several boxes, extremes among them
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					mn = '{32'h80000000, 32'h80000000, 32'h80000000};
					mx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
				end
				1: begin
					mn = '{0, 0, 0};
					mx = '{0, 0, 0};
				end
				default: for (int a = 0; a < 3; a++) begin
					mn[a] = $urandom_range(0, 32'h00080000) - 32'h00040000;
					mx[a] = mn[a] + $urandom_range(0, 32'h00080000);
					if ($urandom_range(0, 7) == 0) mn[a] = pick_coord();
					if ($urandom_range(0, 7) == 0) mx[a] = pick_coord();
				end
			endcase
			write_box(mn, mx);
			for (int k = 0; k < 200; k++) begin
				if (phase == 2 && k == 20) long_hold = 1'b1;
				if (phase == 5 && k == 120) quiet_tail = 1'b1;
				r = random_ray();
				send_ray(r);
			end
			drain();
		end

		$display("%0d rays sent, %0d results checked, %0d hits, over 8 box settings",
			rays_sent, result_count, hit_count);
		if (fail_count == 0)
			$display("ray_box_slab_intersect_top: match");
		else
			$display("ray_box_slab_intersect_top: mismatch");
		$finish;
	end
endmodule
